>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. They are compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Types and constants shared by the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    // Default capacity and stored handle width.
    localparam int DEPTH_DEFAULT        = 64;
    localparam int HANDLE_WIDTH_DEFAULT = 32;

    // Field widths of the transaction payloads.
    localparam int MODE_W     = 3;
    localparam int POSITION_W = 7;
    localparam int HANDLE_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int FOUND_POS_W = 6;
    localparam int COUNT_W    = 7;

    // Operation codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_READ   = 3'd1,
        MODE_WRITE  = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_INSERT = 3'd4,
        MODE_POP    = 3'd5,
        MODE_SEARCH = 3'd6,
        MODE_CLEAR  = 3'd7
    } mode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_POS = 2'd1,
        STATUS_NULL    = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    // Request transaction.
    typedef struct packed {
        mode_t                 mode;
        logic [POSITION_W-1:0] position;
        logic [HANDLE_W-1:0]   handle;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        status_t                status;
        logic [HANDLE_W-1:0]    read_value;
        logic [FOUND_POS_W-1:0] found_position;
        logic                   found;
        logic [COUNT_W-1:0]     entry_count;
        logic                   is_empty;
    } out_item_t;

endpackage

>>> src/ile_ram.sv
// ----------------------------------------------------------------------------
// ile_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ile_ram #(
    parameter int WIDTH = ile_pkg::HANDLE_WIDTH_DEFAULT,
    parameter int DEPTH = ile_pkg::DEPTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; a same-address read returns the old word.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of up to DEPTH nonzero handles held in one block RAM.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one request transaction (mode, position, handle); the
// m_ channel returns exactly one result transaction for each request, in order.
// Requests are taken one at a time: s_ready is high only while the sequencer
// is idle. Append, write, clear and every rejected request finish in the
// decode step; read waits for the registered RAM data, and pop then moves
// the entries above its position down. Remove, pop, insert and search walk
// through the entries, so they take longer the more entries they move or
// scan; search stops at its first match, and insert at the end of the list
// moves nothing.
// The result sits in an output register; a new request is accepted while it
// waits, and a stalled receiver only holds the sequencer in its final state.
// Reset sets the entry count to zero; the RAM contents are not cleared, and
// positions at or above the count never reach a result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_list_engine #(
    parameter int DEPTH        = ile_pkg::DEPTH_DEFAULT,
    parameter int HANDLE_WIDTH = ile_pkg::HANDLE_WIDTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ile_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ile_pkg::out_item_t m_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > ile_pkg::POSITION_W) ? CW : ile_pkg::POSITION_W;
    localparam int HW = HANDLE_WIDTH;
    localparam int OW = ile_pkg::HANDLE_W;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_RD_WAIT  = 6'b000010,
        ST_SHIFT_DN = 6'b000100,
        ST_SHIFT_UP = 6'b001000,
        ST_SEARCH   = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    state_t                             state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [CW-1:0]                      ptr_reg, ptr_next;
    logic                               pend_reg, pend_next;
    logic [AW-1:0]                      pend_addr_reg, pend_addr_next;
    logic [AW-1:0]                      pos_reg, pos_next;
    logic [HW-1:0]                      hnd_reg, hnd_next;
    ile_pkg::mode_t                     mode_reg, mode_next;
    ile_pkg::status_t                   status_reg, status_next;
    logic [OW-1:0]                      rv_reg, rv_next;
    logic [ile_pkg::FOUND_POS_W-1:0]    fpos_reg, fpos_next;
    logic                               found_reg, found_next;
    logic                               m_valid_reg, m_valid_next;
    ile_pkg::out_item_t                 m_data_reg, m_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_wa;
    logic [HW-1:0] ram_wd;
    logic [AW-1:0] ram_ra;
    logic [HW-1:0] ram_rd;

    logic [HW-1:0] h_in;
    logic [PW-1:0] pos_e;
    logic [PW-1:0] cnt_e;
    logic          needs_handle;
    logic          is_full;
    logic          issue;

    // Entry storage.
    ile_ram #(
        .WIDTH(HW),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_wa),
        .wr_data(ram_wd),
        .rd_addr(ram_ra),
        .rd_data(ram_rd)
    );

    // Request decode helpers.
    assign h_in  = HW'({{HW{1'b0}}, s_data.handle});
    assign pos_e = PW'(s_data.position);
    assign cnt_e = PW'(count_reg);
    assign is_full = (count_reg == CW'(DEPTH));
    assign needs_handle = (s_data.mode == ile_pkg::MODE_APPEND) ||
                          (s_data.mode == ile_pkg::MODE_WRITE)  ||
                          (s_data.mode == ile_pkg::MODE_INSERT) ||
                          (s_data.mode == ile_pkg::MODE_SEARCH);

    // Sequencer: decode, walk the RAM, then hand the result to the output.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pos_next       = pos_reg;
        hnd_next       = hnd_reg;
        mode_next      = mode_reg;
        status_next    = status_reg;
        rv_next        = rv_reg;
        fpos_next      = fpos_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_wa         = '0;
        ram_wd         = '0;
        ram_ra         = '0;
        issue          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                ram_ra = AW'(s_data.position);
                if (s_valid) begin
                    mode_next   = s_data.mode;
                    hnd_next    = h_in;
                    pos_next    = AW'(pos_e);
                    status_next = ile_pkg::STATUS_OK;
                    rv_next     = '0;
                    fpos_next   = '0;
                    found_next  = 1'b0;
                    state_next  = ST_DONE;
                    if (needs_handle && (h_in == '0)) begin
                        status_next = ile_pkg::STATUS_NULL;
                    end else begin
                        unique case (s_data.mode) inside
                            ile_pkg::MODE_APPEND: begin
                                if (is_full) begin
                                    status_next = ile_pkg::STATUS_FULL;
                                end else begin
                                    ram_we     = 1'b1;
                                    ram_wa     = AW'(count_reg);
                                    ram_wd     = h_in;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                            ile_pkg::MODE_WRITE: begin
                                if (pos_e > cnt_e) begin
                                    status_next = ile_pkg::STATUS_BAD_POS;
                                end else if (pos_e == cnt_e) begin
                                    if (is_full) begin
                                        status_next = ile_pkg::STATUS_FULL;
                                    end else begin
                                        ram_we     = 1'b1;
                                        ram_wa     = AW'(count_reg);
                                        ram_wd     = h_in;
                                        count_next = count_reg + CW'(1);
                                    end
                                end else begin
                                    ram_we = 1'b1;
                                    ram_wa = AW'(pos_e);
                                    ram_wd = h_in;
                                end
                            end
                            ile_pkg::MODE_READ, ile_pkg::MODE_POP: begin
                                if (pos_e >= cnt_e) begin
                                    status_next = ile_pkg::STATUS_BAD_POS;
                                end else begin
                                    state_next = ST_RD_WAIT;
                                end
                            end
                            ile_pkg::MODE_REMOVE: begin
                                if (pos_e >= cnt_e) begin
                                    status_next = ile_pkg::STATUS_BAD_POS;
                                end else begin
                                    ptr_next   = CW'(pos_e + PW'(1));
                                    state_next = ST_SHIFT_DN;
                                end
                            end
                            ile_pkg::MODE_INSERT: begin
                                if (pos_e > cnt_e) begin
                                    status_next = ile_pkg::STATUS_BAD_POS;
                                end else if (is_full) begin
                                    status_next = ile_pkg::STATUS_FULL;
                                end else begin
                                    ptr_next   = count_reg;
                                    state_next = ST_SHIFT_UP;
                                end
                            end
                            ile_pkg::MODE_SEARCH: begin
                                ptr_next   = '0;
                                state_next = ST_SEARCH;
                            end
                            ile_pkg::MODE_CLEAR: begin
                                count_next = '0;
                            end
                        endcase
                    end
                end
            end

            // Read data is back; pop goes on to close the gap.
            ST_RD_WAIT: begin
                rv_next = OW'({{OW{1'b0}}, ram_rd});
                if (mode_reg == ile_pkg::MODE_POP) begin
                    ptr_next   = CW'(pos_reg) + CW'(1);
                    state_next = ST_SHIFT_DN;
                end else begin
                    state_next = ST_DONE;
                end
            end

            // Move entries above the position down by one, read then write.
            ST_SHIFT_DN: begin
                issue  = (ptr_reg < count_reg);
                ram_ra = AW'(ptr_reg);
                if (pend_reg) begin
                    ram_we = 1'b1;
                    ram_wa = pend_addr_reg - AW'(1);
                    ram_wd = ram_rd;
                end
                if (issue) begin
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(ptr_reg);
                    ptr_next       = ptr_reg + CW'(1);
                end else if (!pend_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_DONE;
                end
            end

            // Move entries from the top down to the position up by one,
            // then place the new handle.
            ST_SHIFT_UP: begin
                issue  = (ptr_reg > CW'(pos_reg));
                ram_ra = AW'(ptr_reg - CW'(1));
                if (pend_reg) begin
                    ram_we = 1'b1;
                    ram_wa = pend_addr_reg + AW'(1);
                    ram_wd = ram_rd;
                end
                if (issue) begin
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(ptr_reg - CW'(1));
                    ptr_next       = ptr_reg - CW'(1);
                end else if (!pend_reg) begin
                    ram_we     = 1'b1;
                    ram_wa     = pos_reg;
                    ram_wd     = hnd_reg;
                    count_next = count_reg + CW'(1);
                    state_next = ST_DONE;
                end
            end

            // Scan from the front; stop at the first match.
            ST_SEARCH: begin
                issue  = (ptr_reg < count_reg);
                ram_ra = AW'(ptr_reg);
                if (pend_reg && (ram_rd == hnd_reg)) begin
                    found_next = 1'b1;
                    fpos_next  = ile_pkg::FOUND_POS_W'(pend_addr_reg);
                    state_next = ST_DONE;
                end else if (issue) begin
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(ptr_reg);
                    ptr_next       = ptr_reg + CW'(1);
                end else if (!pend_reg) begin
                    state_next = ST_DONE;
                end
            end

            // Load the output register once it is free.
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.status         = status_reg;
                    m_data_next.read_value     = rv_reg;
                    m_data_next.found_position = fpos_reg;
                    m_data_next.found          = found_reg;
                    m_data_next.entry_count    = ile_pkg::COUNT_W'(count_reg);
                    m_data_next.is_empty       = (count_reg == '0);
                    state_next                 = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        pos_reg       <= pos_next;
        hnd_reg       <= hnd_next;
        mode_reg      <= mode_next;
        status_reg    <= status_next;
        rv_reg        <= rv_next;
        fpos_reg      <= fpos_next;
        found_reg     <= found_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The entry count never exceeds the capacity.
    `ASSERT_IMPLIES(a_count_range, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH))
    // A pending RAM read only exists while walking the entries.
    `ASSERT_IMPLIES(a_pend_state, aclk, aresetn, pend_reg, (state_reg == ST_SHIFT_DN) || (state_reg == ST_SHIFT_UP) || (state_reg == ST_SEARCH))
    // A freshly loaded result carries the empty flag of the current count.
    `ASSERT_NEXT(a_result_load, aclk, aresetn, (state_reg == ST_DONE) && (!m_valid_reg || m_ready), m_valid_reg && (m_data_reg.is_empty == (count_reg == '0)))

endmodule

>>> tb/sv/indexed_list_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_test
// Self-checking bench for the indexed list engine. A scoreboard keeps its own
// copy of the list, predicts the result of every accepted request and checks
// the results in order. Directed requests cover the corner cases first; then
// random phases grow, shrink and mix the list, with idle gaps on both sides.
// ----------------------------------------------------------------------------
module indexed_list_engine_test;

    localparam int LIST_DEPTH    = ile_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS  = 1730;
    localparam int DRAIN_CYCLES  = LIST_DEPTH + 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} phase_kind_t;

    // Scoreboard: shadow list, queue of predicted results and the checker.
    class list_scoreboard;
        bit [ile_pkg::HANDLE_W-1:0] entries[$];
        ile_pkg::out_item_t         expected_results[$];
        int                         mismatches;
        int                         results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Apply one accepted request to the shadow list and queue its result.
        function void note_request(ile_pkg::in_item_t req);
            ile_pkg::out_item_t         res;
            bit [ile_pkg::HANDLE_W-1:0] h;
            int unsigned                pos;
            int unsigned                len;
            bit                         takes_handle;
            res = '0;
            res.status = ile_pkg::STATUS_OK;
            h = req.handle;
            pos = req.position;
            len = entries.size();
            case (req.mode) inside
                ile_pkg::MODE_APPEND, ile_pkg::MODE_WRITE,
                ile_pkg::MODE_INSERT, ile_pkg::MODE_SEARCH: takes_handle = 1'b1;
                default: takes_handle = 1'b0;
            endcase
            // A null handle is rejected before any position check.
            if (takes_handle && h == '0) begin
                res.status = ile_pkg::STATUS_NULL;
            end else begin
                case (req.mode)
                    ile_pkg::MODE_APPEND: begin
                        if (len >= LIST_DEPTH) res.status = ile_pkg::STATUS_FULL;
                        else entries.push_back(h);
                    end
                    ile_pkg::MODE_READ: begin
                        if (pos >= len) res.status = ile_pkg::STATUS_BAD_POS;
                        else res.read_value = entries[pos];
                    end
                    ile_pkg::MODE_WRITE: begin
                        if (pos > len) res.status = ile_pkg::STATUS_BAD_POS;
                        else if (pos == len && len >= LIST_DEPTH)
                            res.status = ile_pkg::STATUS_FULL;
                        else if (pos == len) entries.push_back(h);
                        else entries[pos] = h;
                    end
                    ile_pkg::MODE_REMOVE: begin
                        if (pos >= len) res.status = ile_pkg::STATUS_BAD_POS;
                        else entries.delete(pos);
                    end
                    ile_pkg::MODE_INSERT: begin
                        if (pos > len) res.status = ile_pkg::STATUS_BAD_POS;
                        else if (len >= LIST_DEPTH) res.status = ile_pkg::STATUS_FULL;
                        else entries.insert(pos, h);
                    end
                    ile_pkg::MODE_POP: begin
                        if (pos >= len) begin
                            res.status = ile_pkg::STATUS_BAD_POS;
                        end else begin
                            res.read_value = entries[pos];
                            entries.delete(pos);
                        end
                    end
                    ile_pkg::MODE_SEARCH: begin
                        for (int i = 0; i < len; i++) begin
                            if (entries[i] == h) begin
                                res.found = 1'b1;
                                res.found_position = ile_pkg::FOUND_POS_W'(i);
                                break;
                            end
                        end
                    end
                    default: entries.delete();
                endcase
            end
            res.entry_count = ile_pkg::COUNT_W'(entries.size());
            res.is_empty = (entries.size() == 0);
            expected_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(ile_pkg::out_item_t got);
            ile_pkg::out_item_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result with nothing pending: %p", got);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.found_position !== want.found_position || got.found !== want.found ||
                got.entry_count !== want.entry_count || got.is_empty !== want.is_empty) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result %0d mismatch:", results_seen);
                    $display("  expected status=%0d read=%h fpos=%0d found=%0d count=%0d empty=%0d",
                             want.status, want.read_value, want.found_position, want.found,
                             want.entry_count, want.is_empty);
                    $display("  actual   status=%0d read=%h fpos=%0d found=%0d count=%0d empty=%0d",
                             got.status, got.read_value, got.found_position, got.found,
                             got.entry_count, got.is_empty);
                end
            end
            results_seen++;
        endfunction
    endclass

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    ile_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    ile_pkg::out_item_t m_data;

    list_scoreboard             sb = new();
    bit                         quiet_phase = 1'b0;
    bit [ile_pkg::HANDLE_W-1:0] handle_pool[12];
    int unsigned                stall_cycles = 0;

    indexed_list_engine uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock and a single reset pulse at the start.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Idle length: mostly none or short, now and then long; none in quiet phases.
    function automatic int unsigned idle_cycles();
        int unsigned r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic ile_pkg::in_item_t make_request(ile_pkg::mode_t mode,
                                                       int unsigned pos,
                                                       bit [ile_pkg::HANDLE_W-1:0] h);
        ile_pkg::in_item_t req;
        req.mode = mode;
        req.position = ile_pkg::POSITION_W'(pos);
        req.handle = h;
        return req;
    endfunction

    // Build a random request that suits the phase and the current list length.
    function automatic ile_pkg::in_item_t next_request(phase_kind_t kind, int unsigned len);
        ile_pkg::mode_t             mode;
        int unsigned                pick;
        int unsigned                pos;
        bit [ile_pkg::HANDLE_W-1:0] h;
        pick = $urandom_range(0, 99);
        case (kind)
            PH_GROW: begin
                if (pick < 40) mode = ile_pkg::MODE_APPEND;
                else if (pick < 65) mode = ile_pkg::MODE_INSERT;
                else if (pick < 85) mode = ile_pkg::MODE_WRITE;
                else if (pick < 90) mode = ile_pkg::MODE_READ;
                else mode = ile_pkg::MODE_SEARCH;
            end
            PH_SHRINK: begin
                if (pick < 30) mode = ile_pkg::MODE_REMOVE;
                else if (pick < 60) mode = ile_pkg::MODE_POP;
                else if (pick < 72) mode = ile_pkg::MODE_READ;
                else if (pick < 84) mode = ile_pkg::MODE_SEARCH;
                else if (pick < 94) mode = ile_pkg::MODE_WRITE;
                else mode = ile_pkg::MODE_INSERT;
            end
            PH_MIXED: mode = ile_pkg::mode_t'($urandom_range(0, int'(ile_pkg::MODE_SEARCH)));
            default: mode = ile_pkg::mode_t'($urandom_range(0, int'(ile_pkg::MODE_CLEAR)));
        endcase
        if (kind != PH_NOISE && $urandom_range(0, 99) == 0) mode = ile_pkg::MODE_CLEAR;

        // Positions: mostly legal, some right at the count, some anywhere.
        pick = $urandom_range(0, 99);
        if (kind == PH_NOISE || pick < 10) pos = $urandom_range(0, 127);
        else if (pick < 20) pos = len;
        else if (mode == ile_pkg::MODE_WRITE || mode == ile_pkg::MODE_INSERT)
            pos = $urandom_range(0, len);
        else pos = (len > 0) ? $urandom_range(0, len - 1) : 0;

        // Handles: a small pool gives repeats and search hits.
        pick = $urandom_range(0, 99);
        if (pick < 5) h = '0;
        else if (pick < 55) h = handle_pool[$urandom_range(0, 11)];
        else h = $urandom;
        return make_request(mode, pos, h);
    endfunction

    // Present one request, hold it until accepted, then idle for a random while, possibly none.
    task automatic send_request(ile_pkg::in_item_t req);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req);
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Result side: ready for a run of cycles, then a random stall.
    initial begin
        int unsigned gap;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            gap = idle_cycles();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Check every result transaction as it is accepted.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus: directed corner cases, then random phases.
    initial begin
        int unsigned sent;
        int unsigned span;
        phase_kind_t kind;
        handle_pool[0] = 32'h0000_0001;
        handle_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 12; i++) handle_pool[i] = $urandom | 32'h1;
        while (!aresetn) @(posedge aclk);

        // Empty list: every positional access is out of range, search misses.
        send_request(make_request(ile_pkg::MODE_READ, 0, '0));
        send_request(make_request(ile_pkg::MODE_REMOVE, 0, '0));
        send_request(make_request(ile_pkg::MODE_POP, 0, '0));
        send_request(make_request(ile_pkg::MODE_SEARCH, 0, 32'hFFFF_FFFF));
        // Null handle wins over a bad position.
        send_request(make_request(ile_pkg::MODE_APPEND, 0, '0));
        send_request(make_request(ile_pkg::MODE_WRITE, 127, '0));
        send_request(make_request(ile_pkg::MODE_INSERT, 127, '0));
        send_request(make_request(ile_pkg::MODE_SEARCH, 0, '0));
        // Build a short list through every way of adding.
        send_request(make_request(ile_pkg::MODE_APPEND, 127, 32'hFFFF_FFFF));
        send_request(make_request(ile_pkg::MODE_APPEND, 0, 32'h0000_0001));
        send_request(make_request(ile_pkg::MODE_WRITE, 2, 32'h8000_0000));
        send_request(make_request(ile_pkg::MODE_WRITE, 4, 32'h1234_5678));
        send_request(make_request(ile_pkg::MODE_WRITE, 1, 32'h0000_0002));
        send_request(make_request(ile_pkg::MODE_INSERT, 0, 32'h5555_5555));
        send_request(make_request(ile_pkg::MODE_INSERT, 4, 32'hAAAA_AAAA));
        send_request(make_request(ile_pkg::MODE_INSERT, 127, 32'h0000_0007));
        // Reads, hits and misses, a pop at the front and a remove at the end.
        send_request(make_request(ile_pkg::MODE_READ, 1, '0));
        send_request(make_request(ile_pkg::MODE_READ, 127, '0));
        send_request(make_request(ile_pkg::MODE_SEARCH, 0, 32'h8000_0000));
        send_request(make_request(ile_pkg::MODE_SEARCH, 0, 32'h0000_0001));
        send_request(make_request(ile_pkg::MODE_POP, 0, '0));
        send_request(make_request(ile_pkg::MODE_REMOVE, 3, '0));
        send_request(make_request(ile_pkg::MODE_CLEAR, 0, '0));
        send_request(make_request(ile_pkg::MODE_CLEAR, 127, 32'hFFFF_FFFF));

        // Random phases; the first one grows the list.
        sent = 0;
        kind = PH_GROW;
        while (sent < RANDOM_ITEMS) begin
            span = $urandom_range(40, 150);
            quiet_phase = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < span && sent < RANDOM_ITEMS; i++) begin
                send_request(next_request(kind, sb.entries.size()));
                sent++;
            end
            kind = phase_kind_t'($urandom_range(0, 3));
        end
        s_valid <= 1'b0;
        quiet_phase = 1'b0;

        // Drain the outstanding results, then allow for stray output.
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatching results, %0d results missing",
                     sb.mismatches, sb.expected_results.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule
